// ----- rtl/core/sdc_pkg.sv -----
// Shared types, codes and helpers of the SD card SPI host controller.
package sdc_pkg;

    localparam int BLOCK_BYTES    = 512;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CSD_BYTES      = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 11;

    // Item kinds.
    localparam logic [2:0] KIND_BYTE = 3'd0;
    localparam logic [2:0] KIND_INIT = 3'd1;
    localparam logic [2:0] KIND_READ = 3'd2;
    localparam logic [2:0] KIND_CAP  = 3'd3;
    localparam logic [2:0] KIND_SYNC = 3'd4;
    localparam logic [2:0] KIND_TICK = 3'd5;

    // Request status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_ERROR     = 2'd1;
    localparam logic [1:0] STAT_NOT_READY = 2'd2;
    localparam logic [1:0] STAT_PARAM     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CMD0_ATTEMPTS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESPONSE_POLLS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_READY_TIMEOUT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TOKEN_TIMEOUT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_TIMEOUT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CMD0_GAP       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_START_DUMMY    = 3'd6;

    // Bus bytes and command framing.
    localparam logic [7:0]  BYTE_IDLE    = 8'hFF;
    localparam logic [7:0]  TOKEN_START  = 8'hFE;
    localparam logic [7:0]  CMD_PREFIX   = 8'h40;
    localparam logic [7:0]  CRC_CMD0     = 8'h95;
    localparam logic [7:0]  CRC_CMD8     = 8'h87;
    localparam logic [7:0]  CRC_NONE     = 8'h01;
    localparam logic [31:0] IF_COND_ARG  = 32'h0000_01AA;
    localparam logic [31:0] HCS_ARG      = 32'h4000_0000;

    // Command indexes.
    localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
    localparam logic [5:0] CMD_SEND_OP    = 6'd1;
    localparam logic [5:0] CMD_IF_COND    = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD   = 6'd9;
    localparam logic [5:0] CMD_STOP       = 6'd12;
    localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
    localparam logic [5:0] CMD_READ_ONE   = 6'd17;
    localparam logic [5:0] CMD_READ_MULTI = 6'd18;
    localparam logic [5:0] CMD_APP_OP     = 6'd41;
    localparam logic [5:0] CMD_APP        = 6'd55;
    localparam logic [5:0] CMD_READ_OCR   = 6'd58;

    // Card type codes.
    localparam logic [3:0] TYPE_NONE     = 4'h0;
    localparam logic [3:0] TYPE_MMC      = 4'h1;
    localparam logic [3:0] TYPE_SD1      = 4'h2;
    localparam logic [3:0] TYPE_SD2      = 4'h4;
    localparam logic [3:0] TYPE_SD2_BLK  = 4'hC;

    typedef enum logic [4:0] {
        PH_IDLE, PH_DUMMY, PH_CMD0, PH_GAP, PH_CMD8, PH_R7, PH_HCS, PH_OCRCMD,
        PH_OCR, PH_PROBE, PH_LEGACY, PH_BLKLEN, PH_RDCMD, PH_CSDCMD, PH_TOKEN,
        PH_DATA, PH_TAIL, PH_STOP, PH_SYSEL, PH_SYWAIT, PH_END
    } phase_t;

    typedef enum logic [2:0] {
        ST_NONE, ST_DESEL, ST_SEL, ST_READY, ST_FAIL, ST_SEND, ST_SKIP, ST_POLL
    } step_t;

    typedef struct packed {
        logic [4:0]  cmd0_attempts;
        logic [3:0]  response_polls;
        logic [10:0] ready_timeout_ms;
        logic [10:0] token_timeout_ms;
        logic [10:0] init_timeout_ms;
        logic [7:0]  cmd0_gap_ms;
        logic [7:0]  start_dummy_bytes;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  rx_byte;
        logic        drive;
        logic [31:0] sector;
        logic [15:0] block_count;
    } item_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        chip_select;
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        last_data;
        logic        done_res;
        logic [1:0]  status;
        logic [3:0]  card_type;
        logic [31:0] sector_count;
    } result_t;

    typedef logic [CSD_BYTES-1:0][7:0] csd_t;

    // Card capacity in sectors from the CSD register, for both layouts.
    function automatic logic [31:0] csd_capacity(csd_t c);
        logic [21:0] sz2;
        logic [12:0] sz1;
        logic [4:0]  n;
        logic [31:0] wide;
        if (c[0][7:6] == 2'b01) begin
            sz2  = {c[7][5:0], c[8], c[9]};
            wide = 32'(sz2) + 32'd1;
            return wide << 10;
        end
        sz1 = 13'({c[6][1:0], c[7], c[8][7:6]}) + 13'd1;
        n   = 5'(c[5][3:0]) + 5'(c[10][7]) + 5'({c[9][1:0], 1'b0}) + 5'd2;
        if (n >= 5'd9) begin
            return 32'(sz1) << (n - 5'd9);
        end
        return 32'(sz1) >> (5'd9 - n);
    endfunction

endpackage

// ----- rtl/core/sdc_if.sv -----
// Valid/ready channel interfaces for request items and result items.
interface sdc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  rx_byte;
    logic        drive;
    logic [31:0] sector;
    logic [15:0] block_count;

    modport source (output valid, kind, rx_byte, drive, sector, block_count, input ready);
    modport sink (input valid, kind, rx_byte, drive, sector, block_count, output ready);
endinterface

interface sdc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        chip_select;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        last_data;
    logic        done_res;
    logic [1:0]  status;
    logic [3:0]  card_type;
    logic [31:0] sector_count;

    modport source (output valid, tx_byte, tx_valid, chip_select, data_byte, data_valid,
                    last_data, done_res, status, card_type, sector_count, input ready);
    modport sink (input valid, tx_byte, tx_valid, chip_select, data_byte, data_valid,
                  last_data, done_res, status, card_type, sector_count, output ready);
endinterface

// ----- rtl/core/sdc_engine.sv -----
// Protocol state machine: one item in, the next bus action and request result out.
module sdc_engine #(
    parameter int COUNT_BITS = sdc_pkg::COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  sdc_pkg::item_t   item,
    input  sdc_pkg::cfg_t    cfg,
    output sdc_pkg::result_t result
);
    import sdc_pkg::*;

    phase_t                phase_reg, phase_next;
    step_t                 step_reg, step_next;
    logic [3:0]            card_kind_reg, card_kind_next;
    logic                  not_ready_reg, not_ready_next;
    logic [9:0]            byte_index_reg, byte_index_next;
    logic [5:0]            command_code_reg, command_code_next;
    logic [31:0]           command_argument_reg, command_argument_next;
    logic                  app_pending_reg, app_pending_next;
    logic [3:0]            polls_left_reg, polls_left_next;
    logic [10:0]           deadline_reg, deadline_next;
    logic [10:0]           init_deadline_reg, init_deadline_next;
    logic [4:0]            attempts_left_reg, attempts_left_next;
    logic [COUNT_BITS-1:0] blocks_left_reg, blocks_left_next;
    logic [31:0]           ocr_shift_reg, ocr_shift_next;
    logic [3:0]            trial_type_reg, trial_type_next;
    logic [2:0]            request_reg, request_next;
    logic [1:0]            end_status_reg, end_status_next;
    logic                  cs_reg, cs_next;
    csd_t                  csd_reg;

    logic                  csd_we;
    logic [3:0]            csd_idx;
    logic [7:0]            csd_wdata;

    logic                  emit_en;
    logic [7:0]            emit_byte;
    logic                  out_dv;
    logic [7:0]            out_data;
    logic                  out_last;
    logic                  out_done;
    logic [1:0]            out_status;
    logic                  out_count;

    // Bytes of a command frame; a pending application prefix sends CMD55 first.
    function automatic logic [7:0] cmd_byte(logic app, logic [5:0] code, logic [31:0] arg,
                                            logic [9:0] i);
        logic [5:0]  c;
        logic [31:0] a;
        c = app ? CMD_APP : code;
        a = app ? 32'd0 : arg;
        case (i)
            10'd0:   return CMD_PREFIX | {2'b00, c};
            10'd1:   return a[31:24];
            10'd2:   return a[23:16];
            10'd3:   return a[15:8];
            10'd4:   return a[7:0];
            default: return (c == CMD_GO_IDLE) ? CRC_CMD0 :
                            (c == CMD_IF_COND) ? CRC_CMD8 : CRC_NONE;
        endcase
    endfunction

    // Next-state logic.
    always_comb
    begin
        logic                  a_resp, a_gap_end, a_block_end, blk_ok, a_fin_init;
        logic                  a_finish, a_token, a_cmd, cmd_app, emit_cs;
        logic [7:0]            resp_val;
        logic [1:0]            fin_status;
        logic [5:0]            cmd_code;
        logic [31:0]           cmd_arg, addr;
        logic [COUNT_BITS-1:0] cnt;
        logic [9:0]            len;

        phase_next            = phase_reg;
        step_next             = step_reg;
        card_kind_next        = card_kind_reg;
        not_ready_next        = not_ready_reg;
        byte_index_next       = byte_index_reg;
        command_code_next     = command_code_reg;
        command_argument_next = command_argument_reg;
        app_pending_next      = app_pending_reg;
        polls_left_next       = polls_left_reg;
        deadline_next         = deadline_reg;
        init_deadline_next    = init_deadline_reg;
        attempts_left_next    = attempts_left_reg;
        blocks_left_next      = blocks_left_reg;
        ocr_shift_next        = ocr_shift_reg;
        trial_type_next       = trial_type_reg;
        request_next          = request_reg;
        end_status_next       = end_status_reg;
        cs_next               = cs_reg;

        csd_we = 1'b0; csd_idx = byte_index_reg[3:0]; csd_wdata = item.rx_byte;
        emit_en = 1'b0; emit_cs = 1'b1; emit_byte = BYTE_IDLE;
        out_dv = 1'b0; out_data = 8'd0; out_last = 1'b0;
        out_done = 1'b0; out_status = STAT_OK; out_count = 1'b0;
        a_resp = 1'b0; resp_val = 8'd0; a_gap_end = 1'b0; a_block_end = 1'b0;
        blk_ok = 1'b0; a_fin_init = 1'b0; a_finish = 1'b0; fin_status = STAT_OK;
        a_token = 1'b0; a_cmd = 1'b0; cmd_code = CMD_GO_IDLE; cmd_arg = 32'd0;
        cmd_app = 1'b0;
        cnt  = COUNT_BITS'(item.block_count);
        addr = item.sector;
        len  = (request_reg == KIND_CAP) ? 10'(CSD_BYTES) : 10'(BLOCK_BYTES);

        if (item.kind == KIND_BYTE) begin
            if (phase_reg != PH_IDLE && phase_reg != PH_GAP) begin
                if (step_reg != ST_NONE) begin
                    case (step_reg)
                        ST_DESEL:
                        begin
                            step_next = ST_SEL;
                            emit_en = 1'b1; emit_cs = 1'b0;
                        end
                        ST_SEL:
                        begin
                            step_next = ST_READY;
                            deadline_next = cfg.ready_timeout_ms;
                            emit_en = 1'b1; emit_cs = 1'b0;
                        end
                        ST_READY:
                        begin
                            if (item.rx_byte == BYTE_IDLE) begin
                                step_next = ST_SEND;
                                byte_index_next = 10'd0;
                                emit_en = 1'b1; emit_cs = 1'b0;
                                emit_byte = cmd_byte(app_pending_reg, command_code_reg,
                                                     command_argument_reg, 10'd0);
                            end else if (deadline_reg == 11'd0) begin
                                step_next = ST_FAIL;
                                emit_en = 1'b1; emit_cs = 1'b1;
                            end else begin
                                emit_en = 1'b1; emit_cs = 1'b0;
                            end
                        end
                        ST_FAIL:
                        begin
                            a_resp = 1'b1; resp_val = BYTE_IDLE;
                        end
                        ST_SEND:
                        begin
                            byte_index_next = byte_index_reg + 10'd1;
                            if (byte_index_next < 10'd6) begin
                                emit_en = 1'b1; emit_cs = 1'b0;
                                emit_byte = cmd_byte(app_pending_reg, command_code_reg,
                                                     command_argument_reg, byte_index_next);
                            end else if (!app_pending_reg && command_code_reg == CMD_STOP) begin
                                // The byte right after CMD12 is a stuff byte.
                                step_next = ST_SKIP;
                                emit_en = 1'b1; emit_cs = 1'b0;
                            end else begin
                                step_next = ST_POLL;
                                polls_left_next = (cfg.response_polls != 4'd0) ?
                                                  cfg.response_polls : 4'd1;
                                emit_en = 1'b1; emit_cs = 1'b0;
                            end
                        end
                        ST_SKIP:
                        begin
                            step_next = ST_POLL;
                            polls_left_next = (cfg.response_polls != 4'd0) ?
                                              cfg.response_polls : 4'd1;
                            emit_en = 1'b1; emit_cs = 1'b0;
                        end
                        default:
                        begin
                            if (!item.rx_byte[7] || polls_left_reg <= 4'd1) begin
                                a_resp = 1'b1; resp_val = item.rx_byte;
                            end else begin
                                polls_left_next = polls_left_reg - 4'd1;
                                emit_en = 1'b1; emit_cs = 1'b0;
                            end
                        end
                    endcase
                end else begin
                    case (phase_reg)
                        PH_DUMMY:
                        begin
                            if (byte_index_reg > 10'd0) begin
                                byte_index_next = byte_index_reg - 10'd1;
                            end
                            if (byte_index_next > 10'd0) begin
                                emit_en = 1'b1; emit_cs = 1'b1;
                            end else begin
                                phase_next = PH_CMD0;
                                a_cmd = 1'b1; cmd_code = CMD_GO_IDLE;
                            end
                        end
                        PH_R7, PH_OCR:
                        begin
                            ocr_shift_next = {ocr_shift_reg[23:0], item.rx_byte};
                            byte_index_next = byte_index_reg + 10'd1;
                            if (byte_index_next < 10'd4) begin
                                emit_en = 1'b1; emit_cs = 1'b0;
                            end else if (phase_reg == PH_OCR) begin
                                trial_type_next = ocr_shift_next[30] ? TYPE_SD2_BLK : TYPE_SD2;
                                a_fin_init = 1'b1;
                            end else if (ocr_shift_next[15:0] == IF_COND_ARG[15:0]) begin
                                init_deadline_next = cfg.init_timeout_ms;
                                phase_next = PH_HCS;
                                a_cmd = 1'b1; cmd_code = CMD_APP_OP; cmd_arg = HCS_ARG;
                                cmd_app = 1'b1;
                            end else begin
                                trial_type_next = TYPE_NONE;
                                a_fin_init = 1'b1;
                            end
                        end
                        PH_TOKEN:
                        begin
                            if (item.rx_byte == BYTE_IDLE && deadline_reg != 11'd0) begin
                                emit_en = 1'b1; emit_cs = 1'b0;
                            end else if (item.rx_byte != TOKEN_START) begin
                                a_block_end = 1'b1; blk_ok = 1'b0;
                            end else begin
                                phase_next = PH_DATA;
                                byte_index_next = 10'd0;
                                emit_en = 1'b1; emit_cs = 1'b0;
                            end
                        end
                        PH_DATA:
                        begin
                            if (request_reg == KIND_CAP) begin
                                csd_we = 1'b1;
                            end else begin
                                out_data = item.rx_byte;
                                out_dv = 1'b1;
                                out_last = (byte_index_reg == len - 10'd1);
                            end
                            byte_index_next = byte_index_reg + 10'd1;
                            if (byte_index_next >= len) begin
                                phase_next = PH_TAIL;
                                byte_index_next = 10'd0;
                            end
                            emit_en = 1'b1; emit_cs = 1'b0;
                        end
                        PH_TAIL:
                        begin
                            byte_index_next = byte_index_reg + 10'd1;
                            if (byte_index_next < 10'd2) begin
                                emit_en = 1'b1; emit_cs = 1'b0;
                            end else begin
                                a_block_end = 1'b1; blk_ok = 1'b1;
                            end
                        end
                        PH_SYSEL:
                        begin
                            phase_next = PH_SYWAIT;
                            deadline_next = cfg.ready_timeout_ms;
                            emit_en = 1'b1; emit_cs = 1'b0;
                        end
                        PH_SYWAIT:
                        begin
                            if (item.rx_byte == BYTE_IDLE) begin
                                a_finish = 1'b1; fin_status = STAT_OK;
                            end else if (deadline_reg == 11'd0) begin
                                a_finish = 1'b1; fin_status = STAT_ERROR;
                            end else begin
                                emit_en = 1'b1; emit_cs = 1'b0;
                            end
                        end
                        PH_END:
                        begin
                            out_done = 1'b1;
                            out_status = end_status_reg;
                            out_count = (request_reg == KIND_CAP) && (end_status_reg == STAT_OK);
                            phase_next = PH_IDLE;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end else if (item.kind == KIND_TICK) begin
            if (deadline_reg > 11'd0) begin
                deadline_next = deadline_reg - 11'd1;
            end
            if (init_deadline_reg > 11'd0) begin
                init_deadline_next = init_deadline_reg - 11'd1;
            end
            if (phase_reg == PH_GAP && deadline_next == 11'd0) begin
                a_gap_end = 1'b1;
            end
        end else if (item.kind <= KIND_SYNC && phase_reg == PH_IDLE) begin
            if (item.drive || (item.kind == KIND_READ && cnt == '0)) begin
                out_done = 1'b1; out_status = STAT_PARAM;
            end else begin
                request_next = item.kind;
                if (item.kind == KIND_INIT) begin
                    trial_type_next = TYPE_NONE;
                    attempts_left_next = (cfg.cmd0_attempts != 5'd0) ? cfg.cmd0_attempts : 5'd1;
                    cs_next = 1'b1;
                    byte_index_next = 10'(cfg.start_dummy_bytes);
                    if (cfg.start_dummy_bytes != 8'd0) begin
                        phase_next = PH_DUMMY;
                        emit_en = 1'b1; emit_cs = 1'b1;
                    end else begin
                        phase_next = PH_CMD0;
                        a_cmd = 1'b1; cmd_code = CMD_GO_IDLE;
                    end
                end else if (not_ready_reg) begin
                    out_done = 1'b1; out_status = STAT_NOT_READY;
                end else if (item.kind == KIND_READ) begin
                    if (!card_kind_reg[3]) begin
                        addr = {item.sector[22:0], 9'd0};
                    end
                    blocks_left_next = cnt;
                    phase_next = PH_RDCMD;
                    a_cmd = 1'b1; cmd_arg = addr;
                    cmd_code = (cnt == COUNT_BITS'(1)) ? CMD_READ_ONE : CMD_READ_MULTI;
                end else if (item.kind == KIND_CAP) begin
                    phase_next = PH_CSDCMD;
                    a_cmd = 1'b1; cmd_code = CMD_SEND_CSD;
                end else begin
                    phase_next = PH_SYSEL;
                    emit_en = 1'b1; emit_cs = 1'b0;
                end
            end
        end

        // A command finished: an application prefix that was accepted sends the
        // real command, anything else goes to the phase that issued it.
        if (a_resp) begin
            step_next = ST_NONE;
            if (app_pending_reg && resp_val <= 8'd1) begin
                app_pending_next = 1'b0;
                step_next = ST_DESEL;
                emit_en = 1'b1; emit_cs = 1'b1;
                a_resp = 1'b0;
            end else begin
                app_pending_next = 1'b0;
            end
        end
        if (a_resp) begin
            case (phase_reg)
                PH_CMD0:
                begin
                    if (resp_val == 8'd1) begin
                        phase_next = PH_CMD8;
                        a_cmd = 1'b1; cmd_code = CMD_IF_COND; cmd_arg = IF_COND_ARG;
                    end else begin
                        if (attempts_left_reg > 5'd0) begin
                            attempts_left_next = attempts_left_reg - 5'd1;
                        end
                        phase_next = PH_GAP;
                        deadline_next = 11'(cfg.cmd0_gap_ms);
                        if (cfg.cmd0_gap_ms == 8'd0) begin
                            a_gap_end = 1'b1;
                        end
                    end
                end
                PH_CMD8:
                begin
                    if (resp_val == 8'd1) begin
                        phase_next = PH_R7;
                        byte_index_next = 10'd0;
                        ocr_shift_next = 32'd0;
                        emit_en = 1'b1; emit_cs = 1'b0;
                    end else begin
                        phase_next = PH_PROBE;
                        a_cmd = 1'b1; cmd_code = CMD_APP_OP; cmd_app = 1'b1;
                    end
                end
                PH_HCS:
                begin
                    if (resp_val == 8'd0 || init_deadline_reg == 11'd0) begin
                        phase_next = PH_OCRCMD;
                        a_cmd = 1'b1; cmd_code = CMD_READ_OCR;
                    end else begin
                        a_cmd = 1'b1; cmd_code = CMD_APP_OP; cmd_arg = HCS_ARG;
                        cmd_app = 1'b1;
                    end
                end
                PH_OCRCMD:
                begin
                    if (resp_val == 8'd0) begin
                        phase_next = PH_OCR;
                        byte_index_next = 10'd0;
                        ocr_shift_next = 32'd0;
                        emit_en = 1'b1; emit_cs = 1'b0;
                    end else begin
                        a_fin_init = 1'b1;
                    end
                end
                PH_PROBE:
                begin
                    trial_type_next = (resp_val <= 8'd1) ? TYPE_SD1 : TYPE_MMC;
                    init_deadline_next = cfg.init_timeout_ms;
                    phase_next = PH_LEGACY;
                    a_cmd = 1'b1;
                    cmd_code = (trial_type_next == TYPE_SD1) ? CMD_APP_OP : CMD_SEND_OP;
                    cmd_app = (trial_type_next == TYPE_SD1);
                end
                PH_LEGACY:
                begin
                    if (resp_val == 8'd0 || init_deadline_reg == 11'd0) begin
                        if (trial_type_reg == TYPE_SD1) begin
                            phase_next = PH_BLKLEN;
                            a_cmd = 1'b1; cmd_code = CMD_BLOCKLEN;
                            cmd_arg = 32'(BLOCK_BYTES);
                        end else begin
                            a_fin_init = 1'b1;
                        end
                    end else begin
                        a_cmd = 1'b1;
                        cmd_code = (trial_type_reg == TYPE_SD1) ? CMD_APP_OP : CMD_SEND_OP;
                        cmd_app = (trial_type_reg == TYPE_SD1);
                    end
                end
                PH_BLKLEN:
                begin
                    if (resp_val != 8'd0) begin
                        trial_type_next = TYPE_NONE;
                    end
                    a_fin_init = 1'b1;
                end
                PH_RDCMD, PH_CSDCMD:
                begin
                    if (resp_val != 8'd0) begin
                        a_finish = 1'b1; fin_status = STAT_ERROR;
                    end else begin
                        a_token = 1'b1;
                    end
                end
                PH_STOP:
                begin
                    a_finish = 1'b1;
                    fin_status = (blocks_left_reg != '0) ? STAT_ERROR : STAT_OK;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (a_gap_end) begin
            if (attempts_left_next == 5'd0) begin
                not_ready_next = 1'b1;
                out_done = 1'b1; out_status = STAT_NOT_READY;
                phase_next = PH_IDLE;
            end else begin
                phase_next = PH_CMD0;
                a_cmd = 1'b1; cmd_code = CMD_GO_IDLE; cmd_arg = 32'd0; cmd_app = 1'b0;
            end
        end

        if (a_block_end) begin
            if (request_reg == KIND_CAP) begin
                a_finish = 1'b1; fin_status = blk_ok ? STAT_OK : STAT_ERROR;
            end else begin
                if (blk_ok) begin
                    blocks_left_next = blocks_left_reg - COUNT_BITS'(1);
                end
                if (blk_ok && blocks_left_next != '0) begin
                    a_token = 1'b1;
                end else if (command_code_reg == CMD_READ_MULTI) begin
                    phase_next = PH_STOP;
                    a_cmd = 1'b1; cmd_code = CMD_STOP;
                end else begin
                    a_finish = 1'b1; fin_status = blk_ok ? STAT_OK : STAT_ERROR;
                end
            end
        end

        if (a_fin_init) begin
            card_kind_next = trial_type_next;
            not_ready_next = (trial_type_next == TYPE_NONE);
            a_finish = 1'b1;
            fin_status = not_ready_next ? STAT_NOT_READY : STAT_OK;
        end

        if (a_cmd) begin
            command_code_next = cmd_code;
            command_argument_next = cmd_arg;
            app_pending_next = cmd_app;
            step_next = ST_DESEL;
            emit_en = 1'b1; emit_cs = 1'b1; emit_byte = BYTE_IDLE;
        end
        if (a_finish) begin
            end_status_next = fin_status;
            phase_next = PH_END;
            emit_en = 1'b1; emit_cs = 1'b1; emit_byte = BYTE_IDLE;
        end
        if (a_token) begin
            phase_next = PH_TOKEN;
            deadline_next = cfg.token_timeout_ms;
            emit_en = 1'b1; emit_cs = 1'b0; emit_byte = BYTE_IDLE;
        end
        if (emit_en) begin
            cs_next = emit_cs;
        end
    end

    // Result assembly.
    always_comb
    begin
        result.tx_byte      = emit_en ? emit_byte : 8'd0;
        result.tx_valid     = emit_en;
        result.chip_select  = cs_next;
        result.data_byte    = out_data;
        result.data_valid   = out_dv;
        result.last_data    = out_last;
        result.done_res     = out_done;
        result.status       = out_status;
        result.card_type    = card_kind_next;
        result.sector_count = out_count ? csd_capacity(csd_reg) : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg            <= PH_IDLE;
            step_reg             <= ST_NONE;
            card_kind_reg        <= TYPE_NONE;
            not_ready_reg        <= 1'b1;
            byte_index_reg       <= 10'd0;
            command_code_reg     <= CMD_GO_IDLE;
            command_argument_reg <= 32'd0;
            app_pending_reg      <= 1'b0;
            polls_left_reg       <= 4'd0;
            deadline_reg         <= 11'd0;
            init_deadline_reg    <= 11'd0;
            attempts_left_reg    <= 5'd0;
            blocks_left_reg      <= '0;
            ocr_shift_reg        <= 32'd0;
            trial_type_reg       <= TYPE_NONE;
            request_reg          <= 3'd0;
            end_status_reg       <= STAT_OK;
            cs_reg               <= 1'b1;
        end else if (step_en) begin
            phase_reg            <= phase_next;
            step_reg             <= step_next;
            card_kind_reg        <= card_kind_next;
            not_ready_reg        <= not_ready_next;
            byte_index_reg       <= byte_index_next;
            command_code_reg     <= command_code_next;
            command_argument_reg <= command_argument_next;
            app_pending_reg      <= app_pending_next;
            polls_left_reg       <= polls_left_next;
            deadline_reg         <= deadline_next;
            init_deadline_reg    <= init_deadline_next;
            attempts_left_reg    <= attempts_left_next;
            blocks_left_reg      <= blocks_left_next;
            ocr_shift_reg        <= ocr_shift_next;
            trial_type_reg       <= trial_type_next;
            request_reg          <= request_next;
            end_status_reg       <= end_status_next;
            cs_reg               <= cs_next;
        end
    end

    // CSD bytes are written in order before the capacity is computed.
    always_ff @(posedge clk)
    begin
        if (step_en && csd_we) begin
            csd_reg[csd_idx] <= csd_wdata;
        end
    end

endmodule

// ----- rtl/core/sd_card_spi_host_controller_unit.sv -----
// Top level of the SD card SPI-mode host controller.
//
// The req channel carries one item per transfer: a finished SPI byte exchange
// (with the byte the card returned), a request (initialize, read blocks,
// capacity query, sync) or a one-millisecond tick. Every accepted item yields
// exactly one result transfer on the rsp channel: the next byte to exchange
// with its start flag, the chip-select level, any block payload byte, and the
// completion flag with status, card type and sector count of a request.
// The item is captured in an input register and its result is computed by the
// state machine step into the result register, which offers it on rsp. One item
// per cycle is sustained while rsp is ready. When rsp is stalled, the result
// register holds its transfer and the input register holds the next item; req
// drops ready only while both are full. Reset deselects the card, marks it not
// initialized and loads the default timing settings; the user must write them on
// the cfg port only while the block is idle, which the block itself leaves
// unchecked.
module sd_card_spi_host_controller_unit #(
    parameter int COUNT_BITS = sdc_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    sdc_in_if.sink                             req,
    sdc_out_if.source                          rsp
);
    import sdc_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t step_res;
    logic    advance;

    // The input stage moves on whenever the result register is free or drains.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.cmd0_attempts     <= 5'd20;
            cfg_reg.response_polls    <= 4'd10;
            cfg_reg.ready_timeout_ms  <= 11'd500;
            cfg_reg.token_timeout_ms  <= 11'd200;
            cfg_reg.init_timeout_ms   <= 11'd1000;
            cfg_reg.cmd0_gap_ms       <= 8'd10;
            cfg_reg.start_dummy_bytes <= 8'd20;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CMD0_ATTEMPTS:  cfg_reg.cmd0_attempts     <= cfg_data[4:0];
                REG_RESPONSE_POLLS: cfg_reg.response_polls    <= cfg_data[3:0];
                REG_READY_TIMEOUT:  cfg_reg.ready_timeout_ms  <= cfg_data;
                REG_TOKEN_TIMEOUT:  cfg_reg.token_timeout_ms  <= cfg_data;
                REG_INIT_TIMEOUT:   cfg_reg.init_timeout_ms   <= cfg_data;
                REG_CMD0_GAP:       cfg_reg.cmd0_gap_ms       <= cfg_data[7:0];
                REG_START_DUMMY:    cfg_reg.start_dummy_bytes <= cfg_data[7:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (req.ready) begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready) begin
            in_item_reg.kind        <= req.kind;
            in_item_reg.rx_byte     <= req.rx_byte;
            in_item_reg.drive       <= req.drive;
            in_item_reg.sector      <= req.sector;
            in_item_reg.block_count <= req.block_count;
        end
    end

    sdc_engine #(
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (step_res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (rsp.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.tx_byte      = out_res_reg.tx_byte;
    assign rsp.tx_valid     = out_res_reg.tx_valid;
    assign rsp.chip_select  = out_res_reg.chip_select;
    assign rsp.data_byte    = out_res_reg.data_byte;
    assign rsp.data_valid   = out_res_reg.data_valid;
    assign rsp.last_data    = out_res_reg.last_data;
    assign rsp.done_res     = out_res_reg.done_res;
    assign rsp.status       = out_res_reg.status;
    assign rsp.card_type    = out_res_reg.card_type;
    assign rsp.sector_count = out_res_reg.sector_count;

    // A new item never lands on a held one.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && in_valid_reg) |-> advance)
        else $error("input register overwritten");

    // A stalled result is never replaced.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !advance)
        else $error("stalled result overwritten");

    // Every processed item leaves a result behind.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost");

    // A payload byte always comes with the next exchange and never ends a request.
    a_payload_exchange: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.data_valid) |-> (step_res.tx_valid && !step_res.done_res))
        else $error("payload byte without follow-up exchange");

endmodule
